@@ rtl/core/heu_pkg.sv @@
// ============================================================================
// heu_pkg - shared types and constants of the HTML entity decoder
// Character codes, job descriptor, and the small lookup functions used by
// the entity classifier.
// ============================================================================
package heu_pkg;

    // Character codes
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Numeric value saturates here while being accumulated
    localparam logic [8:0] VAL_CAP = 9'd256;

    // Entries in the queue between classifier and emitter
    localparam int QUEUE_DEPTH = 4;

    // Named entity bodies
    typedef enum logic [1:0] {
        WORD_AMP,
        WORD_LT,
        WORD_GT,
        WORD_QUOT
    } word_t;

    // Job for the emitter: optional flush of '&' plus held bytes, then an optional tail
    typedef struct packed {
        logic       flush;
        logic       has_tail;
        logic [7:0] tail_byte;
        logic       tail_valid;
        logic       tail_done;
    } job_ctrl_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } digit_t;

    // Check one body character against a named entity at a given position
    function automatic logic word_char_match(word_t w, logic [1:0] pos, logic [7:0] c);
        logic [7:0] want;
        logic       live;
        want = CH_NUL;
        live = 1'b1;
        case (w)
            WORD_AMP:
            begin
                case (pos)
                    2'd0:    want = 8'h61;  // a
                    2'd1:    want = 8'h6D;  // m
                    2'd2:    want = 8'h70;  // p
                    default: live = 1'b0;
                endcase
            end
            WORD_LT:
            begin
                case (pos)
                    2'd0:    want = 8'h6C;  // l
                    2'd1:    want = 8'h74;  // t
                    default: live = 1'b0;
                endcase
            end
            WORD_GT:
            begin
                case (pos)
                    2'd0:    want = 8'h67;  // g
                    2'd1:    want = 8'h74;  // t
                    default: live = 1'b0;
                endcase
            end
            WORD_QUOT:
            begin
                case (pos)
                    2'd0:    want = 8'h71;  // q
                    2'd1:    want = 8'h75;  // u
                    2'd2:    want = 8'h6F;  // o
                    default: want = 8'h74;  // t
                endcase
            end
            default: live = 1'b0;
        endcase
        return live && (c == want);
    endfunction

    // Decimal or hex digit value
    function automatic digit_t digit_value(logic [7:0] c, logic hex);
        digit_t     d;
        logic [7:0] t;
        d = '0;
        t = CH_NUL;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            t = c - 8'h30;
            d.ok = 1'b1;
        end
        else if (hex && c >= 8'h61 && c <= 8'h66)
        begin
            t = c - 8'h57;
            d.ok = 1'b1;
        end
        else if (hex && c >= 8'h41 && c <= 8'h46)
        begin
            t = c - 8'h37;
            d.ok = 1'b1;
        end
        d.value = t[3:0];
        return d;
    endfunction

endpackage

@@ rtl/core/heu_in_if.sv @@
// ============================================================================
// heu_in_if - input byte channel
// Valid/ready channel carrying one string byte or an end-of-string mark.
// ============================================================================
interface heu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       string_end;

    modport source (output valid, character, string_end, input ready);
    modport sink   (input valid, character, string_end, output ready);
endinterface

@@ rtl/core/heu_out_if.sv @@
// ============================================================================
// heu_out_if - output result channel
// Valid/ready channel carrying one decoded byte or an end marker.
// ============================================================================
interface heu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       last_of_run;

    modport source (output valid, out_byte, byte_valid, string_done, last_of_run,
                    input ready);
    modport sink   (input valid, out_byte, byte_valid, string_done, last_of_run,
                    output ready);
endinterface

@@ rtl/core/heu_queue.sv @@
// ============================================================================
// heu_queue - short job queue
// Register-based FIFO between the classifier and the emitter.
// ============================================================================
module heu_queue
    import heu_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/heu_front.sv @@
// ============================================================================
// heu_front - entity classifier
// Accepts bytes, holds entity bodies, tracks which entity the body can still
// be, and issues one emit job per transaction that produces output.
// ============================================================================
module heu_front
    import heu_pkg::*;
#(
    parameter int HOLD_LIMIT = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    heu_in_if.sink                             in_ch,
    input  logic                               q_full,
    output logic                               q_push,
    output job_ctrl_t                          job_ctrl,
    output logic [$clog2(HOLD_LIMIT)-1:0]      job_count,
    output logic [(HOLD_LIMIT-1)*8-1:0]        job_held
);

    localparam int HD = HOLD_LIMIT - 1;
    localparam int CW = $clog2(HOLD_LIMIT);
    localparam int IW = $clog2(HD);

    logic          inside_reg, inside_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    held_reg [HD];
    logic          m_amp_reg, m_amp_next;
    logic          m_lt_reg, m_lt_next;
    logic          m_gt_reg, m_gt_next;
    logic          m_quot_reg, m_quot_next;
    logic          hash_reg, hash_next;
    logic          hex_reg, hex_next;
    logic          num_ok_reg, num_ok_next;
    logic [8:0]    val_reg, val_next;

    logic          accept;
    logic          hold_en;
    logic [7:0]    c;
    logic          in_word;
    logic [7:0]    dec_byte;
    digit_t        dig;
    logic [12:0]   acc;
    logic [12:0]   sum;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign c           = in_ch.character;
    assign job_count   = count_reg;
    assign in_word     = (count_reg < CW'(4));

    // Snapshot held bytes into the job
    always_comb
    begin
        for (int i = 0; i < HD; i++)
        begin
            job_held[i*8 +: 8] = held_reg[i];
        end
    end

    // Decode a closed body: named entity or numeric value, zero when literal
    always_comb
    begin
        dec_byte = CH_NUL;
        if (m_amp_reg && count_reg == CW'(3))
        begin
            dec_byte = CH_AMP;
        end
        else if (m_lt_reg && count_reg == CW'(2))
        begin
            dec_byte = CH_LT;
        end
        else if (m_gt_reg && count_reg == CW'(2))
        begin
            dec_byte = CH_GT;
        end
        else if (m_quot_reg && count_reg == CW'(4))
        begin
            dec_byte = CH_QUOT;
        end
        else if (hash_reg && num_ok_reg && val_reg != '0 && val_reg < VAL_CAP)
        begin
            dec_byte = val_reg[7:0];
        end
    end

    // Accumulate numeric value of the body, saturating at the cap
    always_comb
    begin
        dig = digit_value(c, hex_reg);
        acc = hex_reg ? {val_reg, 4'b0000} : (13'(val_reg) * 13'd10);
        sum = acc + 13'(dig.value);
    end

    // Classify the accepted transaction and build the job
    always_comb
    begin
        inside_next = inside_reg;
        count_next  = count_reg;
        m_amp_next  = m_amp_reg;
        m_lt_next   = m_lt_reg;
        m_gt_next   = m_gt_reg;
        m_quot_next = m_quot_reg;
        hash_next   = hash_reg;
        hex_next    = hex_reg;
        num_ok_next = num_ok_reg;
        val_next    = val_reg;
        hold_en     = 1'b0;
        q_push      = 1'b0;
        job_ctrl    = '0;

        if (accept)
        begin
            if (in_ch.string_end)
            begin
                q_push              = 1'b1;
                job_ctrl.flush      = inside_reg;
                job_ctrl.has_tail   = 1'b1;
                job_ctrl.tail_byte  = CH_NUL;
                job_ctrl.tail_valid = 1'b0;
                job_ctrl.tail_done  = 1'b1;
                inside_next         = 1'b0;
                count_next          = '0;
            end
            else if (inside_reg && c == CH_SEMI && count_reg < CW'(HD))
            begin
                q_push              = 1'b1;
                job_ctrl.has_tail   = 1'b1;
                job_ctrl.tail_valid = 1'b1;
                if (dec_byte != CH_NUL)
                begin
                    job_ctrl.tail_byte = dec_byte;
                end
                else
                begin
                    job_ctrl.flush     = 1'b1;
                    job_ctrl.tail_byte = CH_SEMI;
                end
                inside_next = 1'b0;
                count_next  = '0;
            end
            else if (inside_reg && (c == CH_AMP || count_reg >= CW'(HD)))
            begin
                // Flush the pending entity, then treat this byte afresh
                q_push              = 1'b1;
                job_ctrl.flush      = 1'b1;
                job_ctrl.has_tail   = (c != CH_AMP);
                job_ctrl.tail_byte  = c;
                job_ctrl.tail_valid = 1'b1;
                inside_next         = (c == CH_AMP);
                count_next          = '0;
            end
            else if (inside_reg)
            begin
                // Hold a body byte and narrow down the candidates
                hold_en     = 1'b1;
                count_next  = count_reg + 1'b1;
                m_amp_next  = m_amp_reg && in_word
                              && word_char_match(WORD_AMP, count_reg[1:0], c);
                m_lt_next   = m_lt_reg && in_word
                              && word_char_match(WORD_LT, count_reg[1:0], c);
                m_gt_next   = m_gt_reg && in_word
                              && word_char_match(WORD_GT, count_reg[1:0], c);
                m_quot_next = m_quot_reg && in_word
                              && word_char_match(WORD_QUOT, count_reg[1:0], c);
                if (count_reg == '0)
                begin
                    hash_next = (c == CH_HASH);
                end
                else if (count_reg == CW'(1) && (c == CH_X_LO || c == CH_X_UP))
                begin
                    hex_next = 1'b1;
                end
                else if (!dig.ok)
                begin
                    num_ok_next = 1'b0;
                end
                else
                begin
                    val_next = (sum >= 13'(VAL_CAP)) ? VAL_CAP : sum[8:0];
                end
            end
            else if (c == CH_AMP)
            begin
                inside_next = 1'b1;
                count_next  = '0;
            end
            else
            begin
                q_push              = 1'b1;
                job_ctrl.has_tail   = 1'b1;
                job_ctrl.tail_byte  = c;
                job_ctrl.tail_valid = 1'b1;
            end

            // Open a fresh entity: reset the body trackers
            if (c == CH_AMP && !in_ch.string_end && !hold_en)
            begin
                m_amp_next  = 1'b1;
                m_lt_next   = 1'b1;
                m_gt_next   = 1'b1;
                m_quot_next = 1'b1;
                hash_next   = 1'b0;
                hex_next    = 1'b0;
                num_ok_next = 1'b1;
                val_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            count_reg  <= '0;
            m_amp_reg  <= 1'b1;
            m_lt_reg   <= 1'b1;
            m_gt_reg   <= 1'b1;
            m_quot_reg <= 1'b1;
            hash_reg   <= 1'b0;
            hex_reg    <= 1'b0;
            num_ok_reg <= 1'b1;
            val_reg    <= '0;
        end
        else
        begin
            inside_reg <= inside_next;
            count_reg  <= count_next;
            m_amp_reg  <= m_amp_next;
            m_lt_reg   <= m_lt_next;
            m_gt_reg   <= m_gt_next;
            m_quot_reg <= m_quot_next;
            hash_reg   <= hash_next;
            hex_reg    <= hex_next;
            num_ok_reg <= num_ok_next;
            val_reg    <= val_next;
        end
    end

    // Hold body bytes
    always_ff @(posedge clk)
    begin
        if (hold_en)
        begin
            held_reg[count_reg[IW-1:0]] <= c;
        end
    end

endmodule

@@ rtl/core/heu_back.sv @@
// ============================================================================
// heu_back - result emitter
// Walks each job one result per cycle, while the output is not stalled, into a registered output stage.
// ============================================================================
module heu_back
    import heu_pkg::*;
#(
    parameter int HOLD_LIMIT = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  job_ctrl_t                          job_ctrl,
    input  logic [$clog2(HOLD_LIMIT)-1:0]      job_count,
    input  logic [(HOLD_LIMIT-1)*8-1:0]        job_held,
    output logic                               q_pop,
    heu_out_if.source                          out_ch
);

    localparam int HD = HOLD_LIMIT - 1;
    localparam int CW = $clog2(HOLD_LIMIT);
    localparam int IW = $clog2(HD);
    localparam int PW = $clog2(HOLD_LIMIT + 1);

    logic [PW-1:0] pos_reg, pos_next;
    logic          valid_reg, valid_next;
    logic [7:0]    byte_reg;
    logic          bv_reg;
    logic          done_reg;
    logic          last_reg;

    logic          advance;
    logic          in_flush;
    logic [CW-1:0] idx;
    logic [7:0]    cur_byte;
    logic          cur_bv;
    logic          cur_done;
    logic          cur_last;

    assign out_ch.valid       = valid_reg;
    assign out_ch.out_byte    = byte_reg;
    assign out_ch.byte_valid  = bv_reg;
    assign out_ch.string_done = done_reg;
    assign out_ch.last_of_run = last_reg;

    assign advance = !q_empty && (!valid_reg || out_ch.ready);
    assign q_pop   = advance && cur_last;

    // Select the current result of the head job
    always_comb
    begin
        in_flush = job_ctrl.flush && (pos_reg <= PW'(job_count));
        idx      = CW'(pos_reg - 1'b1);
        if (in_flush)
        begin
            cur_byte = (pos_reg == '0) ? CH_AMP : job_held[idx[IW-1:0]*8 +: 8];
            cur_bv   = 1'b1;
            cur_done = 1'b0;
            cur_last = (pos_reg == PW'(job_count)) && !job_ctrl.has_tail;
        end
        else
        begin
            cur_byte = job_ctrl.tail_byte;
            cur_bv   = job_ctrl.tail_valid;
            cur_done = job_ctrl.tail_done;
            cur_last = 1'b1;
        end
    end

    // Step through the job and hold the output while stalled
    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            pos_next   = cur_last ? '0 : pos_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= cur_byte;
            bv_reg   <= cur_bv;
            done_reg <= cur_done;
            last_reg <= cur_last;
        end
    end

endmodule

@@ rtl/core/html_entity_unescape.sv @@
// ============================================================================
// html_entity_unescape - streaming HTML entity decoder
// Decodes named and numeric character entities in a byte stream.
// ============================================================================
// Usage:
//   in_ch  carries one string byte per transaction, or an end-of-string mark
//          (string_end = 1, character ignored).
//   out_ch carries results: a byte (byte_valid = 1) or the end marker
//          (byte_valid = 0, string_done = 1). last_of_run marks the final
//          result caused by one input transaction.
//   A byte outside an entity gives one result. An '&' and the body bytes after
//   it give no result until the entity closes; then one decoded byte, or the
//   literal '&', body and trailing byte, up to HOLD_LIMIT + 1 results.
// Each job is registered in the job queue, then its results in the output stage.
// Throughput: one input transaction per cycle while the queue is not full and
//   one result per cycle while out_ch.ready is high; the emitter works through a
//   flush result by result while the classifier keeps accepting into the
//   QUEUE_DEPTH job queue.
// Reset: clears the pending entity, the job queue and the output stage.
// Stall: when out_ch.ready is low the output holds; the queue fills and then
//   in_ch.ready drops until results drain.
// ============================================================================
module html_entity_unescape
    import heu_pkg::*;
#(
    parameter int HOLD_LIMIT = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    heu_in_if.sink    in_ch,
    heu_out_if.source out_ch
);

    localparam int HD     = HOLD_LIMIT - 1;
    localparam int CW     = $clog2(HOLD_LIMIT);
    localparam int CTRL_W = $bits(job_ctrl_t);
    localparam int QW     = CTRL_W + HD*8 + CW;

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    job_ctrl_t       push_ctrl;
    logic [CW-1:0]   push_count;
    logic [HD*8-1:0] push_held;
    logic [QW-1:0]   head_data;
    job_ctrl_t       head_ctrl;
    logic [CW-1:0]   head_count;
    logic [HD*8-1:0] head_held;

    heu_front #(.HOLD_LIMIT(HOLD_LIMIT)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .q_push    (q_push),
        .job_ctrl  (push_ctrl),
        .job_count (push_count),
        .job_held  (push_held)
    );

    heu_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_count, push_held, push_ctrl}),
        .pop       (q_pop),
        .head_data (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Unpack the head job
    assign head_ctrl  = head_data[CTRL_W-1:0];
    assign head_held  = head_data[CTRL_W +: HD*8];
    assign head_count = head_data[CTRL_W + HD*8 +: CW];

    heu_back #(.HOLD_LIMIT(HOLD_LIMIT)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .job_ctrl  (head_ctrl),
        .job_count (head_count),
        .job_held  (head_held),
        .q_pop     (q_pop),
        .out_ch    (out_ch)
    );

    // Never pop an empty queue
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    // End of string closes its run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.string_done |-> out_ch.last_of_run && !out_ch.byte_valid)
        else $error("end marker not last of run or carries a byte");

    // A marker without a byte only at end of string
    a_marker_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.byte_valid |-> out_ch.string_done)
        else $error("result without byte outside end of string");

endmodule
